FILE: hdl/ptpc_pkg.sv
// ----------------------------------------------------------------------------
// ptpc_pkg
// Shared types and constants for the prescaled timer with periodic compare.
// ----------------------------------------------------------------------------
package ptpc_pkg;

    // Stream widths
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 6;
    localparam int OUT_DATA_W = 40;
    localparam int REG_W      = 32;

    // Item kinds carried in the low bits of the slave-side tuser.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // Register indexes.
    localparam logic [3:0] REG_GCTRL    = 4'd0;
    localparam logic [3:0] REG_COMPCTRL = 4'd1;
    localparam logic [3:0] REG_FRC0     = 4'd2;
    localparam logic [3:0] REG_UC0      = 4'd3;
    localparam logic [3:0] REG_CPUC0    = 4'd4;
    localparam logic [3:0] REG_FRC1     = 4'd5;
    localparam logic [3:0] REG_UC1      = 4'd6;
    localparam logic [3:0] REG_CPUC1    = 4'd7;
    localparam logic [3:0] REG_COMP1    = 4'd8;
    localparam logic [3:0] REG_UDCP1    = 4'd9;
    localparam logic [3:0] REG_SETINT   = 4'd10;
    localparam logic [3:0] REG_CLRINT   = 4'd11;
    localparam logic [3:0] REG_INTFLAG  = 4'd12;

    // Bit positions inside the register words.
    localparam int BIT_CMP1 = 1;
    localparam int BIT_OVL1 = 18;
    localparam int BIT_SEL1 = 4;

    // Per-block control strobes from the register logic to a counter block.
    typedef struct packed {
        logic tick;      // enabled clock tick
        logic wr_free;   // load free-running counter
        logic wr_pre;    // load up counter
        logic wr_lim;    // load compare-up value
        logic latch;     // capture up counter for a later read
    } t_cnt_ctrl;

    // Per-block tick status back to the compare logic.
    typedef struct packed {
        logic stepped;   // free-running counter advanced on this tick
        logic wrapped;   // free-running counter wrapped to zero
    } t_cnt_stat;

    // Interrupt bits {overflow, compare} to register word layout.
    function automatic logic [REG_W-1:0] to_reg_bits(input logic [1:0] v);
        logic [REG_W-1:0] w;
        begin
            w           = '0;
            w[BIT_CMP1] = v[0];
            w[BIT_OVL1] = v[1];
            return w;
        end
    endfunction

    function automatic logic [1:0] from_reg_bits(input logic [REG_W-1:0] w);
        return {w[BIT_OVL1], w[BIT_CMP1]};
    endfunction

endpackage

FILE: hdl/ptpc_counter.sv
// ----------------------------------------------------------------------------
// ptpc_counter
// One counter block: prescaling up counter, compare-up value, free-running
// counter and the latched up-counter copy.
// ----------------------------------------------------------------------------
module ptpc_counter #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ptpc_pkg::t_cnt_ctrl      i_ctrl,
    input  logic [COUNTER_WIDTH-1:0] i_wdata,
    output ptpc_pkg::t_cnt_stat      o_stat,
    output logic [COUNTER_WIDTH-1:0] o_free,
    output logic [COUNTER_WIDTH-1:0] o_free_inc,
    output logic [COUNTER_WIDTH-1:0] o_limit,
    output logic [COUNTER_WIDTH-1:0] o_latched
);
    import ptpc_pkg::*;

    logic [COUNTER_WIDTH-1:0] r_free, n_free;
    logic [COUNTER_WIDTH-1:0] r_pre, n_pre;
    logic [COUNTER_WIDTH-1:0] r_lim;
    logic [COUNTER_WIDTH-1:0] r_lat;
    logic                     r_hold, n_hold;
    logic [COUNTER_WIDTH-1:0] w_pre_inc;
    logic                     w_inc;

    assign w_pre_inc  = r_pre + 1'b1;
    assign o_free_inc = r_free + 1'b1;

    always_comb begin
        n_free = r_free;
        n_pre  = r_pre;
        n_hold = r_hold;
        w_inc  = 1'b0;
        if (i_ctrl.tick) begin
            if (r_hold) begin
                // Extra tick of a zero-limit period.
                n_hold = 1'b0;
            end else if (r_lim == '0) begin
                n_pre = w_pre_inc;
                if (w_pre_inc == '0) begin
                    w_inc  = 1'b1;
                    n_hold = 1'b1;
                end
            end else if (r_pre == r_lim) begin
                n_pre = '0;
                w_inc = 1'b1;
            end else begin
                n_pre = w_pre_inc;
            end
            if (w_inc) begin
                n_free = o_free_inc;
            end
        end else if (i_ctrl.wr_free) begin
            n_free = i_wdata;
        end else if (i_ctrl.wr_pre) begin
            n_pre  = i_wdata;
            n_hold = 1'b0;
        end
    end

    assign o_stat.stepped = w_inc;
    assign o_stat.wrapped = w_inc && (o_free_inc == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '0;
            r_pre  <= '0;
            r_lim  <= '0;
            r_lat  <= '0;
            r_hold <= 1'b0;
        end else begin
            r_free <= n_free;
            r_pre  <= n_pre;
            r_hold <= n_hold;
            if (i_ctrl.wr_lim) begin
                r_lim <= i_wdata;
            end
            if (i_ctrl.latch) begin
                r_lat <= r_pre;
            end
        end
    end

    assign o_free    = r_free;
    assign o_limit   = r_lim;
    assign o_latched = r_lat;

endmodule

FILE: hdl/prescaled_timer_with_periodic_compare.sv
// ----------------------------------------------------------------------------
// prescaled_timer_with_periodic_compare
// Timer peripheral with two prescaled counter blocks, a periodic compare on
// the selected free-running counter and a counter 1 overflow interrupt.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata (low bit first)                tuser
//  s_axis    in         wdata[31:0]                          op[1:0], reg_index[5:2]
//  m_axis    out        rdata[31:0], irq, compare_hit,       none
//                       overflow_hit, zero fill [39:35]
//
// Every transaction passes from the input register to the result register,
// and a new transaction is taken in every cycle while the result
// side keeps up; the whole state update is one pass of short logic.
// The result is written to the result register when its transaction
// leaves the input register, and it is held there until it is taken.
// When m_axis stalls, the input register holds one more transaction and then
// s_axis_tready drops until the result is taken.
// Reset is synchronous and active low and clears counters, flags and timer state.
// ----------------------------------------------------------------------------
module prescaled_timer_with_periodic_compare #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // wdata
    input  logic [ptpc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op [1:0], reg_index [5:2]
    input  logic [ptpc_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // rdata [31:0], irq [32], compare_hit [33], overflow_hit [34], zeros above
    output logic [ptpc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import ptpc_pkg::*;

    // Input register.
    logic                     r_in_valid;
    t_op                      r_op;
    logic [3:0]               r_idx;
    logic [REG_W-1:0]         r_wdata;

    // Result register.
    logic                     r_out_valid;
    logic [REG_W-1:0]         r_rdata;
    logic                     r_irq;
    logic                     r_chit;
    logic                     r_ohit;

    // Global registers.
    logic [1:0]               r_en;
    logic                     r_sel;
    logic [COUNTER_WIDTH-1:0] r_cmp, n_cmp;
    logic [COUNTER_WIDTH-1:0] r_upd;
    logic [1:0]               r_ie, n_ie;
    logic [1:0]               r_if, n_if;

    logic                     w_adv;
    logic                     w_tick, w_wr, w_rd;
    logic [COUNTER_WIDTH-1:0] w_wdata;
    logic [REG_W-1:0]         w_rdata;
    logic                     w_chit;
    logic                     w_ohit;

    t_cnt_ctrl                w_ctrl [2];
    t_cnt_stat                w_stat [2];
    logic [COUNTER_WIDTH-1:0] w_free [2];
    logic [COUNTER_WIDTH-1:0] w_finc [2];
    logic [COUNTER_WIDTH-1:0] w_lim  [2];
    logic [COUNTER_WIDTH-1:0] w_lat  [2];

    // The held transaction moves on when the result register is free or
    // being emptied in this cycle.
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    assign w_tick  = w_adv && (r_op == OP_TICK);
    assign w_wr    = w_adv && (r_op == OP_WRITE);
    assign w_rd    = w_adv && (r_op == OP_READ);
    assign w_wdata = r_wdata[COUNTER_WIDTH-1:0];

    // Strobes into the two counter blocks.
    always_comb begin
        w_ctrl[0].tick    = w_tick && r_en[0];
        w_ctrl[0].wr_free = w_wr && (r_idx == REG_FRC0);
        w_ctrl[0].wr_pre  = w_wr && (r_idx == REG_UC0);
        w_ctrl[0].wr_lim  = w_wr && (r_idx == REG_CPUC0);
        w_ctrl[0].latch   = w_rd && (r_idx == REG_FRC0);
        w_ctrl[1].tick    = w_tick && r_en[1];
        w_ctrl[1].wr_free = w_wr && (r_idx == REG_FRC1);
        w_ctrl[1].wr_pre  = w_wr && (r_idx == REG_UC1);
        w_ctrl[1].wr_lim  = w_wr && (r_idx == REG_CPUC1);
        w_ctrl[1].latch   = w_rd && (r_idx == REG_FRC1);
    end

    for (genvar b = 0; b < 2; b++) begin : g_blk
        ptpc_counter #(
            .COUNTER_WIDTH (COUNTER_WIDTH)
        ) u_counter (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl[b]),
            .i_wdata    (w_wdata),
            .o_stat     (w_stat[b]),
            .o_free     (w_free[b]),
            .o_free_inc (w_finc[b]),
            .o_limit    (w_lim[b]),
            .o_latched  (w_lat[b])
        );
    end

    // Compare 1 fires only when the selected counter steps onto the compare
    // value; the compare value then moves on by the update value.
    always_comb begin
        w_chit = w_tick && (r_sel ? (w_stat[1].stepped && (w_finc[1] == r_cmp))
                                  : (w_stat[0].stepped && (w_finc[0] == r_cmp)));
        w_ohit = w_tick && w_stat[1].wrapped;
        n_cmp  = r_cmp;
        if (w_chit) begin
            n_cmp = r_cmp + r_upd;
        end else if (w_wr && (r_idx == REG_COMP1)) begin
            n_cmp = w_wdata;
        end
    end

    // Interrupt enables and flags; flags are set by events and cleared by
    // writing ones to the flag register.
    always_comb begin
        n_ie = r_ie;
        n_if = r_if;
        if (w_wr && (r_idx == REG_SETINT)) begin
            n_ie = r_ie | from_reg_bits(r_wdata);
        end
        if (w_wr && (r_idx == REG_CLRINT)) begin
            n_ie = r_ie & ~from_reg_bits(r_wdata);
        end
        if (w_wr && (r_idx == REG_INTFLAG)) begin
            n_if = r_if & ~from_reg_bits(r_wdata);
        end
        if (w_chit) begin
            n_if[0] = 1'b1;
        end
        if (w_ohit) begin
            n_if[1] = 1'b1;
        end
    end

    // Register read mux, using the values before this transaction.
    always_comb begin
        w_rdata = '0;
        if (r_op == OP_READ) begin
            unique case (r_idx)
                REG_GCTRL:    w_rdata = REG_W'(r_en);
                REG_COMPCTRL: w_rdata = REG_W'(r_sel) << BIT_SEL1;
                REG_FRC0:     w_rdata = REG_W'(w_free[0]);
                REG_UC0:      w_rdata = REG_W'(w_lat[0]);
                REG_CPUC0:    w_rdata = REG_W'(w_lim[0]);
                REG_FRC1:     w_rdata = REG_W'(w_free[1]);
                REG_UC1:      w_rdata = REG_W'(w_lat[1]);
                REG_CPUC1:    w_rdata = REG_W'(w_lim[1]);
                REG_COMP1:    w_rdata = REG_W'(r_cmp);
                REG_UDCP1:    w_rdata = REG_W'(r_upd);
                REG_SETINT:   w_rdata = to_reg_bits(r_ie);
                REG_CLRINT:   w_rdata = to_reg_bits(r_ie);
                REG_INTFLAG:  w_rdata = to_reg_bits(r_if);
                default:      w_rdata = '0;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op    <= t_op'(s_axis_tuser[1:0]);
            r_idx   <= s_axis_tuser[5:2];
            r_wdata <= s_axis_tdata;
        end
    end

    // Timer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= '0;
            r_sel <= 1'b0;
            r_cmp <= '0;
            r_upd <= '0;
            r_ie  <= '0;
            r_if  <= '0;
        end else begin
            r_cmp <= n_cmp;
            r_ie  <= n_ie;
            r_if  <= n_if;
            if (w_wr && (r_idx == REG_GCTRL)) begin
                r_en <= r_wdata[1:0];
            end
            if (w_wr && (r_idx == REG_COMPCTRL)) begin
                r_sel <= r_wdata[BIT_SEL1];
            end
            if (w_wr && (r_idx == REG_UDCP1)) begin
                r_upd <= w_wdata;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rdata <= w_rdata;
            r_irq   <= |(n_if & n_ie);
            r_chit  <= w_chit;
            r_ohit  <= w_ohit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_ohit, r_chit, r_irq, r_rdata};

endmodule
